[rtl/core/ikc3_pkg.sv]
package ikc3_pkg;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from address bits [3:2].
   localparam logic [1:0] REG_KERNEL_MODE  = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   // Kernel selection codes.
   localparam logic KERNEL_EDGE    = 1'b0;
   localparam logic KERNEL_LAPLACE = 1'b1;

   // Field widths.
   localparam int PIXEL_W = 8;
   localparam int DIM_W   = 11;
   localparam int COORD_W = 10;
   localparam int SUM_W   = 11;

   // Register reset values.
   localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH  = 11'd1000;
   localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT = 11'd500;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   typedef logic [PIXEL_W-1:0]      pixel_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   // One line buffer word: the same column of the two rows above.
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_pair_type;

endpackage

[rtl/core/image_kernel_convolution_3x3.sv]
// 3x3 convolution of an 8-bit grey pixel stream in raster order. One request is
// taken every clock cycle when the response side keeps up. The request that completes
// a window passes through stage one (the line buffer read) and then the output
// register, which takes the kernel sum. The two rows above the current one live
// in a single two-port RAM of MAX_WIDTH words, read at acceptance and written
// back as stage one moves on; when back-to-back requests touch the same column,
// the write data is forwarded past the RAM. Border pixels give no response. The
// line buffer needs no clearing pass after reset: every entry read for a response
// has been written earlier in the same frame.
module image_kernel_convolution_3x3 #(
   parameter int MAX_WIDTH  = ikc3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ikc3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ikc3_pkg::PIXEL_W-1:0]   req_pixel,
   input  logic                           req_frame_start,
   // Response channel.
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ikc3_pkg::PIXEL_W-1:0]   rsp_out_pixel,
   output logic signed [ikc3_pkg::SUM_W-1:0] rsp_raw_sum,
   output logic [ikc3_pkg::COORD_W-1:0]   rsp_out_row,
   output logic [ikc3_pkg::COORD_W-1:0]   rsp_out_col,
   output logic                           rsp_last,
   // Configuration port.
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ikc3_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ikc3_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ikc3_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import ikc3_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int DW0 = (WW > HW) ? WW : HW;
   localparam int DW  = (DW0 > DIM_W) ? DW0 : DIM_W;

   // Configuration registers.
   logic             mode_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic             csr_write;
   logic [1:0]       csr_index;

   // Dimensions clamped to the supported range.
   logic [DW-1:0] width_ext;
   logic [DW-1:0] height_ext;
   logic [DW-1:0] w_dim;
   logic [DW-1:0] h_dim;

   // Position counters.
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic [CW-1:0] col_cur;
   logic [RW-1:0] row_cur;
   logic [DW-1:0] c_ext;
   logic [DW-1:0] r_ext;
   logic          req_fire;
   logic          has_cur;
   logic          last_cur;

   // Stage one: line buffer data is back from the RAM.
   logic               s1_valid_ff;
   logic               s1_has_ff;
   logic               s1_last_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic [COORD_W-1:0] s1_col_ff;
   pixel_type          s1_px_ff;
   logic [CW-1:0]      s1_idx_ff;
   logic               s1_adv;
   logic               fwd_ff;
   line_pair_type      fwd_data_ff;
   line_pair_type      ram_rdata;
   line_pair_type      line_cur;
   line_pair_type      wr_data;
   sum_type            sum;

   // Output register.
   logic               rsp_valid_ff;
   pixel_type          rsp_pixel_ff;
   sum_type            rsp_sum_ff;
   logic [COORD_W-1:0] rsp_row_ff;
   logic [COORD_W-1:0] rsp_col_ff;
   logic               rsp_last_ff;

   // Configuration writes and reads.
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= KERNEL_EDGE;
         width_ff  <= RESET_IMAGE_WIDTH;
         height_ff <= RESET_IMAGE_HEIGHT;
      end else if (csr_write) begin
         case (csr_index)
            REG_KERNEL_MODE:  mode_ff   <= csr_pwdata[0];
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_KERNEL_MODE:  csr_prdata = CSR_DATA_W'(mode_ff);
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Clamp the dimensions to 3..MAX.
   assign width_ext  = DW'(width_ff);
   assign height_ext = DW'(height_ff);

   always_comb begin
      if (width_ext < DW'(3)) begin
         w_dim = DW'(3);
      end else if (width_ext > DW'(MAX_WIDTH)) begin
         w_dim = DW'(MAX_WIDTH);
      end else begin
         w_dim = width_ext;
      end
      if (height_ext < DW'(3)) begin
         h_dim = DW'(3);
      end else if (height_ext > DW'(MAX_HEIGHT)) begin
         h_dim = DW'(MAX_HEIGHT);
      end else begin
         h_dim = height_ext;
      end
   end

   // Position of the incoming pixel; a frame start restarts at the origin.
   assign req_fire = req_valid & req_ready;
   assign col_cur  = req_frame_start ? '0 : col_ff;
   assign row_cur  = req_frame_start ? '0 : row_ff;
   assign c_ext    = DW'(col_cur);
   assign r_ext    = DW'(row_cur);

   // The pixel completes the window centred one row up and one column left.
   assign has_cur  = (r_ext >= DW'(2)) && (r_ext <= h_dim - DW'(1))
                     && (c_ext >= DW'(2)) && (c_ext <= w_dim - DW'(1));
   assign last_cur = (r_ext == h_dim - DW'(1)) && (c_ext == w_dim - DW'(1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (c_ext + DW'(1) >= w_dim) begin
            col_in = '0;
            row_in = (r_ext + DW'(1) >= h_dim) ? '0 : RW'(r_ext + DW'(1));
         end else begin
            col_in = CW'(c_ext + DW'(1));
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage one moves on unless its response finds the output register full.
   assign s1_adv    = s1_valid_ff & (~s1_has_ff | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_adv;

   // Line buffer: read at acceptance, written back as stage one moves on.
   ikc3_ram #(
      .WIDTH ($bits(line_pair_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_idx_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (col_cur),
      .rd_data (ram_rdata)
   );

   assign line_cur      = fwd_ff ? fwd_data_ff : ram_rdata;
   assign wr_data.older = line_cur.newer;
   assign wr_data.newer = s1_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Capture the request and note a same-column write that the RAM read misses.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_has_ff   <= has_cur;
         s1_last_ff  <= last_cur;
         s1_row_ff   <= COORD_W'(r_ext - DW'(1));
         s1_col_ff   <= COORD_W'(c_ext - DW'(1));
         s1_px_ff    <= req_pixel;
         s1_idx_ff   <= col_cur;
         fwd_ff      <= s1_adv && (s1_idx_ff == col_cur);
         fwd_data_ff <= wr_data;
      end
   end

   ikc3_window u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .mode    (mode_ff),
      .n_older (line_cur.older),
      .n_newer (line_cur.newer),
      .n_pixel (s1_px_ff),
      .sum     (sum)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_has_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_has_ff) begin
         rsp_pixel_ff <= sum[PIXEL_W-1:0];
         rsp_sum_ff   <= sum;
         rsp_row_ff   <= s1_row_ff;
         rsp_col_ff   <= s1_col_ff;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_raw_sum   = rsp_sum_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef ASSERT_OFF
   // A blocked response in stage one must hold off new requests.
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_has_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while stage one is blocked");

   // A read of the column being written must take the forwarded data.
   a_fwd_on_match: assert property (@(posedge clock) disable iff (reset)
      req_fire && s1_adv && (s1_idx_ff == col_cur) |=> fwd_ff)
      else $error("same-column read not forwarded");

   // An accepted request occupies stage one in the next cycle.
   a_fire_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request lost before stage one");

   // An interior result never reports row 0 or column 0.
   a_no_border: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0) && (rsp_col_ff != '0))
      else $error("response on a border pixel");
`endif

endmodule

[rtl/core/ikc3_ram.sv]
module ikc3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ikc3_window.sv]
module ikc3_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               mode,
   input  ikc3_pkg::pixel_type n_older,
   input  ikc3_pkg::pixel_type n_newer,
   input  ikc3_pkg::pixel_type n_pixel,
   output ikc3_pkg::sum_type   sum
);
   import ikc3_pkg::*;

   // Column a is two pixels back, column b one pixel back; index 0 is the top row.
   pixel_type a_ff [3];
   pixel_type b_ff [3];
   pixel_type a_in [3];
   pixel_type b_in [3];

   sum_type edge_pos;
   sum_type edge_neg;
   sum_type lap_sum;

   // The window shifts left by one column as each request leaves stage one.
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (advance) begin
         a_in    = b_ff;
         b_in[0] = n_older;
         b_in[1] = n_newer;
         b_in[2] = n_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= '0;
            b_ff[i] <= '0;
         end
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   // Vertical edge kernel: left column minus right column.
   assign edge_pos = SUM_W'(a_ff[0]) + SUM_W'(a_ff[1]) + SUM_W'(a_ff[2]);
   assign edge_neg = SUM_W'(n_older) + SUM_W'(n_newer) + SUM_W'(n_pixel);

   // Laplacian: four times the centre minus its four direct neighbors.
   assign lap_sum = sum_type'({b_ff[1], 2'b00}) - SUM_W'(b_ff[0]) - SUM_W'(b_ff[2])
                    - SUM_W'(a_ff[1]) - SUM_W'(n_newer);

   always_comb begin
      case (mode)
         KERNEL_EDGE:    sum = edge_pos - edge_neg;
         KERNEL_LAPLACE: sum = lap_sum;
         default:        sum = edge_pos - edge_neg;
      endcase
   end

endmodule
